// ===== hdl/bpsm_pkg.sv =====
// shared types, constants and codes of the battery power state monitor
package bpsm_pkg;

    localparam int unsigned MV_W     = 14;
    localparam int unsigned TICK_W   = 32;
    localparam int unsigned CYCLE_W  = 16;
    localparam int unsigned TENTH_W  = 13;
    localparam int unsigned LEVEL_W  = 4;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned CIDX_W   = 3;
    localparam int unsigned CDATA_W  = 32;
    localparam int unsigned NUM_STEPS = 10;

    // reciprocal of ten for 16-bit dividends: (x * 52429) >> 19
    localparam logic [15:0] RECIP_TEN   = 16'd52429;
    localparam int unsigned RECIP_SHIFT = 19;

    localparam logic [MV_W-1:0] INIT_MV = 14'd3700;

    typedef enum logic [1:0] {
        ST_CHARGED  = 2'd0,
        ST_CHARGING = 2'd1,
        ST_LOWPOWER = 2'd2,
        ST_BATTERY  = 2'd3
    } power_state_t;

    typedef enum logic [CIDX_W-1:0] {
        REG_LOW_MV     = 3'd0,
        REG_CRIT_MV    = 3'd1,
        REG_LOW_TO     = 3'd2,
        REG_CRIT_TO    = 3'd3,
        REG_INACT_TO   = 3'd4,
        REG_CYCLE      = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [MV_W-1:0]    low_mv;
        logic [MV_W-1:0]    crit_mv;
        logic [TICK_W-1:0]  low_to;
        logic [TICK_W-1:0]  crit_to;
        logic [TICK_W-1:0]  inact_to;
        logic [CYCLE_W-1:0] cycle;
        logic [TENTH_W-1:0] cycle_tenth;
    } cfg_t;

    localparam logic [MV_W-1:0] LEVEL_TABLE_MV [NUM_STEPS] = '{
        14'd3000, 14'd3780, 14'd3830, 14'd3870, 14'd3890,
        14'd3920, 14'd3960, 14'd4000, 14'd4040, 14'd4100
    };

endpackage

// ===== hdl/bpsm_if.sv =====
// channel interfaces: samples in, results out, register writes
interface bpsm_in_if;
    import bpsm_pkg::*;
    logic                valid;
    logic                ready;
    logic [MV_W-1:0]     battery_mv;
    logic                charging;
    logic                power_good;
    logic [TICK_W-1:0]   now_ticks;
    logic [TICK_W-1:0]   inactivity_ticks;

    modport source (output valid, battery_mv, charging, power_good, now_ticks,
                    inactivity_ticks, input ready);
    modport sink   (input valid, battery_mv, charging, power_good, now_ticks,
                    inactivity_ticks, output ready);
endinterface

interface bpsm_out_if;
    import bpsm_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          power_state;
    logic                state_changed;
    logic                can_fly;
    logic [PCT_W-1:0]    level_percent;
    logic [CYCLE_W-1:0]  led_on_ticks;
    logic [CYCLE_W-1:0]  led_off_ticks;
    logic                shutdown_request;
    logic [MV_W-1:0]     min_mv;
    logic [MV_W-1:0]     max_mv;

    modport source (output valid, power_state, state_changed, can_fly, level_percent,
                    led_on_ticks, led_off_ticks, shutdown_request, min_mv, max_mv,
                    input ready);
    modport sink   (input valid, power_state, state_changed, can_fly, level_percent,
                    led_on_ticks, led_off_ticks, shutdown_request, min_mv, max_mv,
                    output ready);
endinterface

interface bpsm_cfg_if;
    import bpsm_pkg::*;
    logic                valid;
    logic                ready;
    logic [CIDX_W-1:0]   index;
    logic [CDATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/bpsm_cfg.sv =====
// configuration register file with precomputed led cycle tenth
module bpsm_cfg (
    input  logic            clk,
    input  logic            rst_n,
    bpsm_cfg_if.sink        cfg,
    output bpsm_pkg::cfg_t  regs
);
    import bpsm_pkg::*;

    cfg_t                       regs_reg;
    cfg_t                       regs_next;
    logic [2*CYCLE_W-1:0]       tenth_prod;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    assign tenth_prod = cfg.data[CYCLE_W-1:0] * RECIP_TEN;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_LOW_MV:   regs_next.low_mv   = cfg.data[MV_W-1:0];
                REG_CRIT_MV:  regs_next.crit_mv  = cfg.data[MV_W-1:0];
                REG_LOW_TO:   regs_next.low_to   = cfg.data[TICK_W-1:0];
                REG_CRIT_TO:  regs_next.crit_to  = cfg.data[TICK_W-1:0];
                REG_INACT_TO: regs_next.inact_to = cfg.data[TICK_W-1:0];
                REG_CYCLE:
                begin
                    regs_next.cycle       = cfg.data[CYCLE_W-1:0];
                    regs_next.cycle_tenth = tenth_prod[RECIP_SHIFT +: TENTH_W];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.low_mv      <= 14'd3200;
            regs_reg.crit_mv     <= 14'd3000;
            regs_reg.low_to      <= 32'd5000;
            regs_reg.crit_to     <= 32'd120000;
            regs_reg.inact_to    <= 32'd300000;
            regs_reg.cycle       <= 16'd1000;
            regs_reg.cycle_tenth <= 13'd100;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== hdl/bpsm_level.sv =====
// ten-step voltage table lookup giving the charge level
module bpsm_level (
    input  logic [bpsm_pkg::MV_W-1:0]    mv,
    output logic [bpsm_pkg::LEVEL_W-1:0] level
);
    import bpsm_pkg::*;

    logic [NUM_STEPS-1:0] above;

    always_comb
    begin
        for (int i = 0; i < NUM_STEPS; i++)
        begin
            above[i] = (mv > LEVEL_TABLE_MV[i]);
        end
    end

    // thresholds rise; the last step is left out of the count, so it caps at nine
    always_comb
    begin
        level = '0;
        for (int i = 0; i < NUM_STEPS - 1; i++)
        begin
            level = level + LEVEL_W'(above[i]);
        end
    end

endmodule

// ===== hdl/battery_power_state_monitor.sv =====
// top level: sample register, state decision, running stats and result register
//
// usage:
//   sample channel: one item per periodic sample (voltage, charger flags,
//     tick count, inactivity time); taken when valid and ready are high
//   result channel: one item per sample, in order, with state, change flag,
//     can-fly flag, charge level, led times, shutdown request and min/max mv
//   cfg channel: register writes by index, always ready; write only while idle
//   latency: a sample accepted at edge n gives its result valid after edge n+1
//   throughput: one item per cycle; the sample register and the result
//     register form a two-stage pipeline, state is updated as an item moves
//     into the result register
//   stall: a result that waits for ready holds; one more sample is taken into
//     the sample register, after that sample ready drops until the result moves
//   reset: both stages empty, min/max at 3700 mv, stamps zero, previous state
//     on battery, registers at their default values
module battery_power_state_monitor (
    input  logic        clk,
    input  logic        rst_n,
    bpsm_in_if.sink     sample,
    bpsm_out_if.source  result,
    bpsm_cfg_if.sink    cfg
);
    import bpsm_pkg::*;

    cfg_t                 regs;

    // sample stage
    logic                 s_valid_reg;
    logic [MV_W-1:0]      s_mv_reg;
    logic                 s_chg_reg;
    logic                 s_pgood_reg;
    logic [TICK_W-1:0]    s_now_reg;
    logic [TICK_W-1:0]    s_inact_reg;

    // running state
    logic [MV_W-1:0]      lo_mv_reg,  lo_mv_next;
    logic [MV_W-1:0]      hi_mv_reg,  hi_mv_next;
    logic [TICK_W-1:0]    low_stamp_reg,  low_stamp_next;
    logic [TICK_W-1:0]    crit_stamp_reg, crit_stamp_next;
    power_state_t         prev_state_reg;

    // result stage
    logic                 r_valid_reg;
    power_state_t         r_state_reg;
    logic                 r_changed_reg;
    logic [PCT_W-1:0]     r_pct_reg;
    logic [CYCLE_W-1:0]   r_on_reg;
    logic [CYCLE_W-1:0]   r_off_reg;
    logic                 r_shut_reg;

    logic                 advance;
    logic                 take;
    logic [LEVEL_W-1:0]   level;
    power_state_t         state_next;
    logic [TICK_W-1:0]    low_elapsed;
    logic [TICK_W-1:0]    crit_elapsed;
    logic [CYCLE_W-1:0]   on_next;
    logic [CYCLE_W-1:0]   off_next;
    logic                 shut_next;
    logic [PCT_W-1:0]     pct_next;
    logic [LEVEL_W+TENTH_W-1:0] on_prod;

    bpsm_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    bpsm_level u_level (
        .mv    (s_mv_reg),
        .level (level)
    );

    assign advance      = s_valid_reg && (!r_valid_reg || result.ready);
    assign take         = sample.valid && sample.ready;
    assign sample.ready = !s_valid_reg || advance;

    always_comb
    begin
        hi_mv_next      = (s_mv_reg > hi_mv_reg) ? s_mv_reg : hi_mv_reg;
        lo_mv_next      = (s_mv_reg < lo_mv_reg) ? s_mv_reg : lo_mv_reg;
        low_stamp_next  = (s_mv_reg > regs.low_mv)  ? s_now_reg : low_stamp_reg;
        crit_stamp_next = (s_mv_reg > regs.crit_mv) ? s_now_reg : crit_stamp_reg;
        low_elapsed     = s_now_reg - low_stamp_next;
        crit_elapsed    = s_now_reg - crit_stamp_next;
    end

    always_comb
    begin
        priority if (s_pgood_reg && !s_chg_reg)
            state_next = ST_CHARGED;
        else if (s_pgood_reg)
            state_next = ST_CHARGING;
        else if (!s_chg_reg && (low_elapsed > regs.low_to))
            state_next = ST_LOWPOWER;
        else
            state_next = ST_BATTERY;
    end

    assign on_prod  = level * regs.cycle_tenth;
    assign pct_next = PCT_W'({level, 3'b000}) + PCT_W'({level, 1'b0});

    always_comb
    begin
        on_next   = '0;
        off_next  = '0;
        shut_next = 1'b0;
        unique case (state_next)
            ST_CHARGING:
            begin
                on_next  = on_prod[CYCLE_W-1:0];
                off_next = regs.cycle - on_prod[CYCLE_W-1:0];
            end
            ST_LOWPOWER: shut_next = (crit_elapsed > regs.crit_to);
            ST_BATTERY:  shut_next = (s_inact_reg > regs.inact_to);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg    <= 1'b0;
            r_valid_reg    <= 1'b0;
            lo_mv_reg      <= INIT_MV;
            hi_mv_reg      <= INIT_MV;
            low_stamp_reg  <= '0;
            crit_stamp_reg <= '0;
            prev_state_reg <= ST_BATTERY;
        end
        else
        begin
            if (take)
                s_valid_reg <= 1'b1;
            else if (advance)
                s_valid_reg <= 1'b0;

            if (advance)
                r_valid_reg <= 1'b1;
            else if (result.ready)
                r_valid_reg <= 1'b0;

            if (advance)
            begin
                lo_mv_reg      <= lo_mv_next;
                hi_mv_reg      <= hi_mv_next;
                low_stamp_reg  <= low_stamp_next;
                crit_stamp_reg <= crit_stamp_next;
                prev_state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s_mv_reg    <= sample.battery_mv;
            s_chg_reg   <= sample.charging;
            s_pgood_reg <= sample.power_good;
            s_now_reg   <= sample.now_ticks;
            s_inact_reg <= sample.inactivity_ticks;
        end
        if (advance)
        begin
            r_state_reg   <= state_next;
            r_changed_reg <= (state_next != prev_state_reg);
            r_pct_reg     <= pct_next;
            r_on_reg      <= on_next;
            r_off_reg     <= off_next;
            r_shut_reg    <= shut_next;
        end
    end

    assign result.valid            = r_valid_reg;
    assign result.power_state      = r_state_reg;
    assign result.state_changed    = r_changed_reg;
    assign result.can_fly          = (r_state_reg == ST_LOWPOWER) ||
                                     (r_state_reg == ST_BATTERY);
    assign result.level_percent    = r_pct_reg;
    assign result.led_on_ticks     = r_on_reg;
    assign result.led_off_ticks    = r_off_reg;
    assign result.shutdown_request = r_shut_reg;
    // running min/max registers move with the result register
    assign result.min_mv           = lo_mv_reg;
    assign result.max_mv           = hi_mv_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench for the battery power state monitor: directed and random samples, predictor checks
module tb;
    import bpsm_pkg::*;

    typedef struct {
        logic [MV_W-1:0]   mv;
        bit                charging;
        bit                power_good;
        logic [TICK_W-1:0] now;
        logic [TICK_W-1:0] inact;
    } sample_t;

    typedef struct {
        power_state_t       state;
        bit                 changed;
        bit                 can_fly;
        logic [PCT_W-1:0]   pct;
        logic [CYCLE_W-1:0] led_on;
        logic [CYCLE_W-1:0] led_off;
        bit                 shutdown;
        logic [MV_W-1:0]    min_mv;
        logic [MV_W-1:0]    max_mv;
    } reading_t;

    typedef logic [CDATA_W-1:0] reg_values_t [6];

    localparam reg_values_t RESET_VALUES = '{3200, 3000, 5000, 120000, 300000, 1000};

    // indexes past the last register, writes there must be dropped
    localparam logic [CIDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CIDX_W-1:0] REG_SPARE_HI = 3'd7;

    class power_state_tracker;
        logic [MV_W-1:0]    low_mv;
        logic [MV_W-1:0]    crit_mv;
        logic [TICK_W-1:0]  low_to;
        logic [TICK_W-1:0]  crit_to;
        logic [TICK_W-1:0]  inact_to;
        logic [CYCLE_W-1:0] cycle;
        logic [MV_W-1:0]    lowest;
        logic [MV_W-1:0]    highest;
        logic [TICK_W-1:0]  low_stamp;
        logic [TICK_W-1:0]  crit_stamp;
        power_state_t       prev_state;
        reading_t           pending_readings[$];
        int                 errors;
        int                 n_samples;
        int                 n_checked;
        int                 n_changes;
        int                 n_shutdowns;
        int                 state_hits[4];

        function new();
            for (int i = 0; i < 6; i++)
                write_reg(i[CIDX_W-1:0], RESET_VALUES[i]);
            lowest = INIT_MV;
            highest = INIT_MV;
            low_stamp = '0;
            crit_stamp = '0;
            prev_state = ST_BATTERY;
            errors = 0;
            n_samples = 0;
            n_checked = 0;
            n_changes = 0;
            n_shutdowns = 0;
            state_hits = '{default: 0};
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
            case (idx)
                REG_LOW_MV:   low_mv = data[MV_W-1:0];
                REG_CRIT_MV:  crit_mv = data[MV_W-1:0];
                REG_LOW_TO:   low_to = data[TICK_W-1:0];
                REG_CRIT_TO:  crit_to = data[TICK_W-1:0];
                REG_INACT_TO: inact_to = data[TICK_W-1:0];
                REG_CYCLE:    cycle = data[CYCLE_W-1:0];
                default:      ;
            endcase
        endfunction

        function reading_t predict_reading(sample_t s);
            reading_t          r;
            int unsigned       level;
            logic [TICK_W-1:0] on_time;
            logic [TICK_W-1:0] low_elapsed;
            logic [TICK_W-1:0] crit_elapsed;
            if (s.mv > highest)
                highest = s.mv;
            if (s.mv < lowest)
                lowest = s.mv;
            level = 0;
            foreach (LEVEL_TABLE_MV[i])
                if (s.mv > LEVEL_TABLE_MV[i])
                    level++;
            if (level > NUM_STEPS - 1)
                level = NUM_STEPS - 1;
            // stamps move before the state is decided
            if (s.mv > low_mv)
                low_stamp = s.now;
            if (s.mv > crit_mv)
                crit_stamp = s.now;
            low_elapsed = s.now - low_stamp;
            crit_elapsed = s.now - crit_stamp;
            if (s.power_good && !s.charging)
                r.state = ST_CHARGED;
            else if (s.power_good)
                r.state = ST_CHARGING;
            else if (!s.charging && low_elapsed > low_to)
                r.state = ST_LOWPOWER;
            else
                r.state = ST_BATTERY;
            r.changed = (r.state != prev_state);
            prev_state = r.state;
            r.can_fly = (r.state == ST_LOWPOWER || r.state == ST_BATTERY);
            r.pct = PCT_W'(level * 10);
            r.led_on = '0;
            r.led_off = '0;
            r.shutdown = 1'b0;
            case (r.state)
                ST_CHARGING:
                begin
                    on_time = level * (cycle / 10);
                    r.led_on = on_time[CYCLE_W-1:0];
                    r.led_off = cycle - on_time[CYCLE_W-1:0];
                end
                ST_LOWPOWER: r.shutdown = (crit_elapsed > crit_to);
                ST_BATTERY:  r.shutdown = (s.inact > inact_to);
                default:     ;
            endcase
            r.min_mv = lowest;
            r.max_mv = highest;
            return r;
        endfunction

        function void note_sample(sample_t s);
            pending_readings.push_back(predict_reading(s));
            n_samples++;
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (pending_readings.size() == 0)
            begin
                $error("result with no sample waiting: state %0d", got.state);
                errors++;
                return;
            end
            want = pending_readings.pop_front();
            check_field("power_state", want.state, got.state);
            check_field("state_changed", want.changed, got.changed);
            check_field("can_fly", want.can_fly, got.can_fly);
            check_field("level_percent", want.pct, got.pct);
            check_field("led_on_ticks", want.led_on, got.led_on);
            check_field("led_off_ticks", want.led_off, got.led_off);
            check_field("shutdown_request", want.shutdown, got.shutdown);
            check_field("min_mv", want.min_mv, got.min_mv);
            check_field("max_mv", want.max_mv, got.max_mv);
            n_checked++;
            state_hits[want.state]++;
            n_changes += want.changed;
            n_shutdowns += want.shutdown;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    bpsm_in_if  in_ch ();
    bpsm_out_if out_ch ();
    bpsm_cfg_if cfg_ch ();

    battery_power_state_monitor u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (in_ch),
        .result (out_ch),
        .cfg    (cfg_ch)
    );

    power_state_tracker sb;
    int                 send_idle_pct = 33;
    int                 recv_stall_pct = 82;
    int                 recv_hold = 0;
    logic [TICK_W-1:0]  tick_now;

    always #6 clk = ~clk;

    initial
    begin
        #4_800_000;
        $display("FAIL");
        $finish;
    end

    // result side: random stalls, plus a long hold-off when asked
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_hold > 0)
            begin
                out_ch.ready <= 1'b0;
                recv_hold--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        reading_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.state = power_state_t'(out_ch.power_state);
            got.changed = out_ch.state_changed;
            got.can_fly = out_ch.can_fly;
            got.pct = out_ch.level_percent;
            got.led_on = out_ch.led_on_ticks;
            got.led_off = out_ch.led_off_ticks;
            got.shutdown = out_ch.shutdown_request;
            got.min_mv = out_ch.min_mv;
            got.max_mv = out_ch.max_mv;
            sb.check_reading(got);
        end
    end

    // called at a falling edge; valid stays high afterwards for back-to-back items
    task automatic drive_sample(input logic [MV_W-1:0] mv, input bit chg, input bit pg,
                                input logic [TICK_W-1:0] now, input logic [TICK_W-1:0] inact);
        sample_t s;
        s.mv = mv;
        s.charging = chg;
        s.power_good = pg;
        s.now = now;
        s.inact = inact;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.battery_mv <= mv;
        in_ch.charging <= chg;
        in_ch.power_good <= pg;
        in_ch.now_ticks <= now;
        in_ch.inactivity_ticks <= inact;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        sb.note_sample(s);
        @(negedge clk);
    endtask

    task automatic put_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic write_regs(input reg_values_t vals, input bit with_spares);
        for (int i = 0; i < 6; i++)
            put_reg(i[CIDX_W-1:0], vals[i]);
        if (with_spares)
        begin
            put_reg(REG_SPARE_LO, $urandom);
            put_reg(REG_SPARE_HI, $urandom);
        end
        cfg_ch.valid <= 1'b0;
        repeat (2) @(negedge clk);
    endtask

    // sender stops until every pending result is out
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending_readings.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // mostly runs of samples with advancing ticks and a wandering voltage, some pure noise
    task automatic run_random(input int count);
        int                done;
        int                len;
        int                mode;
        int                walk;
        logic [TICK_W-1:0] step_max;
        logic [TICK_W-1:0] inact;
        bit                chg;
        bit                pg;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(99) < 80)
            begin
                len = $urandom_range(24, 4);
                mode = $urandom_range(3);
                case ($urandom_range(3))
                    0:       walk = sb.low_mv;
                    1:       walk = sb.crit_mv;
                    2:       walk = LEVEL_TABLE_MV[$urandom_range(NUM_STEPS - 1)];
                    default: walk = $urandom_range((1 << MV_W) - 1);
                endcase
                case ($urandom_range(3))
                    0:       step_max = sb.low_to >> 2;
                    1:       step_max = sb.low_to;
                    2:       step_max = sb.crit_to >> 2;
                    default: step_max = $urandom;
                endcase
                repeat (len)
                begin
                    walk = walk + int'($urandom_range(80)) - 40;
                    if (walk < 0)
                        walk = 0;
                    if (walk > (1 << MV_W) - 1)
                        walk = (1 << MV_W) - 1;
                    tick_now += $urandom_range(step_max);
                    case (mode)
                        0:
                        begin
                            pg = 1'b0;
                            chg = ($urandom_range(9) == 0);
                        end
                        1:
                        begin
                            pg = 1'b1;
                            chg = ($urandom_range(4) != 0);
                        end
                        2:
                        begin
                            pg = ($urandom_range(9) == 0);
                            chg = 1'($urandom_range(1));
                        end
                        default:
                        begin
                            pg = 1'($urandom_range(1));
                            chg = 1'($urandom_range(1));
                        end
                    endcase
                    case ($urandom_range(2))
                        0:       inact = sb.inact_to + $urandom_range(2) - 1;
                        1:       inact = $urandom_range(sb.inact_to);
                        default: inact = $urandom;
                    endcase
                    drive_sample(walk[MV_W-1:0], chg, pg, tick_now, inact);
                    done++;
                end
            end
            else
            begin
                drive_sample(MV_W'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                             $urandom, $urandom);
                done++;
            end
        end
    endtask

    initial
    begin
        reg_values_t vals;
        in_ch.valid = 1'b0;
        in_ch.battery_mv = '0;
        in_ch.charging = 1'b0;
        in_ch.power_good = 1'b0;
        in_ch.now_ticks = '0;
        in_ch.inactivity_ticks = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        sb = new();
        tick_now = $urandom;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part on reset register values
        drive_sample(14'd0, 1'b0, 1'b0, 32'd0, 32'd0);
        drive_sample('1, 1'b0, 1'b1, 32'd1, 32'd0);
        // every table threshold, on it for even steps and just above it for odd ones
        foreach (LEVEL_TABLE_MV[i])
            drive_sample(LEVEL_TABLE_MV[i] + MV_W'(i % 2), 1'b1, 1'b1, 32'd2, 32'd0);
        drive_sample(14'd4101, 1'b1, 1'b1, 32'd3, 32'd0);
        // inactivity exactly at the limit, then one past it
        drive_sample(14'd3960, 1'b0, 1'b0, 32'd10, 32'd300000);
        drive_sample(14'd3200, 1'b0, 1'b0, 32'd5010, 32'd300001);
        drive_sample(14'd3100, 1'b0, 1'b0, 32'd5011, 32'd0);
        // charging flag without power good stays on battery
        drive_sample(14'd3000, 1'b1, 1'b0, 32'd125011, 32'd0);
        // critical time at the limit, then one past it
        drive_sample(14'd3000, 1'b0, 1'b0, 32'd125011, '1);
        drive_sample(14'd2999, 1'b0, 1'b0, 32'd125012, '1);
        // stamps at the top of the tick range, elapsed time across the wrap
        drive_sample('1, 1'b0, 1'b0, '1, '1);
        drive_sample(14'd0, 1'b0, 1'b0, 32'd4999, 32'd0);
        drive_sample(14'd0, 1'b0, 1'b0, 32'd5000, 32'd0);
        drive_sample(14'd3500, 1'b0, 1'b1, 32'd5001, '1);
        drive_sample(14'd3500, 1'b1, 1'b1, 32'd5002, '1);
        drain();

        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg)
                1:       vals = '{default: '0};
                3:       vals = '{default: '1};
                4:       foreach (vals[i]) vals[i] = $urandom;
                5:       vals = RESET_VALUES;
                default:
                begin
                    vals[0] = $urandom_range(3900, 3100);
                    vals[1] = $urandom_range(vals[0], 2900);
                    vals[2] = $urandom_range(20000);
                    vals[3] = $urandom_range(200000);
                    vals[4] = $urandom_range(400000);
                    vals[5] = $urandom_range(65535);
                end
            endcase
            write_regs(vals, seg == 0 || seg == 3);
            if (seg == 2)
            begin
                send_idle_pct = 82;
                recv_stall_pct = 33;
            end
            if (seg == 4)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                // long hold-off while samples keep coming, fills the pipeline
                recv_hold = 64;
            end
            run_random(255);
            drain();
        end

        $display("checked %0d results from %0d samples, six register reloads incl. all-zero",
                 sb.n_checked, sb.n_samples);
        $display("charged %0d charging %0d low %0d battery %0d, %0d changes, %0d shutdowns",
                 sb.state_hits[ST_CHARGED], sb.state_hits[ST_CHARGING],
                 sb.state_hits[ST_LOWPOWER], sb.state_hits[ST_BATTERY],
                 sb.n_changes, sb.n_shutdowns);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bpsm_pkg.sv
hdl/bpsm_if.sv
hdl/bpsm_cfg.sv
hdl/bpsm_level.sv
hdl/battery_power_state_monitor.sv
tb/tb.sv
